/* rtl/core/raycast_column_texel_mapper_unit_macros.svh */
// Assertion macros for the raycast column texel mapper.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RAYCAST_COLUMN_TEXEL_MAPPER_UNIT_MACROS_SVH
`define RAYCAST_COLUMN_TEXEL_MAPPER_UNIT_MACROS_SVH

// same-cycle implication
`define RCTM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rctm same-cycle check failed");

// next-cycle implication
`define RCTM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rctm next-cycle check failed");

`endif

/* rtl/core/rctm_pkg.sv */
// Shared types and constants of the raycast column texel mapper.
// No dependencies; imported by every module of the block.
`default_nettype none

package rctm_pkg;

    // field widths
    localparam int DIST_W  = 24;
    localparam int DIR_W   = 18;
    localparam int FRAC_W  = 32;
    localparam int LH_W    = 16;
    localparam int NUMER_W = 25;
    localparam int QUOT_W  = 8;
    localparam int TEX_W   = 9;

    localparam int S_DATA_W = 152;
    localparam int M_DATA_W = 72;
    localparam int CFG_IDX_W = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CEIL_COLOR  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_COLOR = 4'd3;

    localparam logic [TEX_W-1:0] TEX_SIZE_RESET = 9'd64;
    localparam logic [TEX_W-1:0] TEX_SIZE_MAX   = 9'd256;
    localparam logic [TEX_W-1:0] TEX_SIZE_MIN   = 9'd1;

    // item kinds
    localparam logic KIND_SETUP = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // pixel classes
    localparam logic [1:0] CLASS_CEILING = 2'd0;
    localparam logic [1:0] CLASS_WALL    = 2'd1;
    localparam logic [1:0] CLASS_FLOOR   = 2'd2;

    // wall faces: side of the grid line and step direction
    localparam logic [1:0] FACE_YS_POS = 2'd0;
    localparam logic [1:0] FACE_XS_POS = 2'd1;
    localparam logic [1:0] FACE_YS_NEG = 2'd2;
    localparam logic [1:0] FACE_XS_NEG = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP_MUL,
        ST_SETUP_SCALE,
        ST_SETUP_MIRROR,
        ST_PIX_NUMER,
        ST_PIX_START,
        ST_PIX_DIVIDE,
        ST_PIX_INDEX,
        ST_RESULT
    } rctm_state_t;

    typedef struct packed {
        logic done;
        logic over;
    } rctm_div_stat_t;

    // zero acts as 1, anything above 256 as 256
    function automatic logic [TEX_W-1:0] rctm_tex_size(input logic [TEX_W-1:0] v);
        logic [TEX_W-1:0] r;
        if (v == '0) begin
            r = TEX_SIZE_MIN;
        end else if (v > TEX_SIZE_MAX) begin
            r = TEX_SIZE_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/rctm_mul_serial.sv */
// Bit-serial multiply-accumulate for the wall hit fraction (low 32 bits kept).
// Depends on rctm_pkg.
`default_nettype none

module rctm_mul_serial
    import rctm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIST_W-1:0] dist_in,
    input  wire logic [FRAC_W-1:0] dir_in,
    input  wire logic [FRAC_W-1:0] acc_init,
    output logic                   done,
    output logic [FRAC_W-1:0]      product
);

    localparam int CNT_W = $clog2(DIST_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIST_W-1:0] dist_sr_reg;
    logic [FRAC_W-1:0] dir_reg;
    logic [FRAC_W-1:0] acc_reg;
    logic [FRAC_W-1:0] acc_next;

    // one multiplier bit per cycle, multiplicand walks left
    always_comb begin
        acc_next = dist_sr_reg[0] ? acc_reg + dir_reg : acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(DIST_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIST_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dist_sr_reg <= dist_in;
            dir_reg     <= dir_in;
            acc_reg     <= acc_init;
        end else if (busy_reg) begin
            dist_sr_reg <= {1'b0, dist_sr_reg[DIST_W-1:1]};
            dir_reg     <= {dir_reg[FRAC_W-2:0], 1'b0};
            acc_reg     <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

/* rtl/core/rctm_div_serial.sv */
// Radix-2 restoring divider for the texture row: quotient limited to 8 bits,
// with an overflow flag when the quotient would reach 256. Depends on rctm_pkg.
`default_nettype none

module rctm_div_serial
    import rctm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [NUMER_W-1:0] numer_in,
    input  wire logic [LH_W-1:0]    divisor_in,
    output rctm_div_stat_t          stat,
    output logic [QUOT_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(QUOT_W);

    logic              busy_reg;
    logic              done_reg;
    logic              over_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [LH_W-1:0]   rem_reg;
    logic [QUOT_W-1:0] low_sr_reg;
    logic [LH_W-1:0]   div_reg;
    logic [QUOT_W-1:0] quot_reg;

    logic [LH_W:0]     trial;
    logic [LH_W+1:0]   diff;
    logic              fits;
    logic [LH_W-1:0]   rem_next;

    always_comb begin
        trial    = {rem_reg, low_sr_reg[QUOT_W-1]};
        diff     = {1'b0, trial} - {2'b00, div_reg};
        fits     = !diff[LH_W+1];
        rem_next = fits ? diff[LH_W-1:0] : trial[LH_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(QUOT_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUOT_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // high part >= divisor means quotient >= 256
            over_reg   <= numer_in[NUMER_W-1:QUOT_W] >= {1'b0, divisor_in};
            rem_reg    <= numer_in[NUMER_W-2:QUOT_W];
            low_sr_reg <= numer_in[QUOT_W-1:0];
            div_reg    <= divisor_in;
            quot_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg    <= rem_next;
            low_sr_reg <= {low_sr_reg[QUOT_W-2:0], 1'b0};
            quot_reg   <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign stat.done = done_reg;
    assign stat.over = over_reg;
    assign quotient  = quot_reg;

endmodule

`default_nettype wire

/* rtl/core/raycast_column_texel_mapper_unit.sv */
// Raycast column texel mapper. A setup word (tuser 0) loads one screen column's
// ray hit; the face comes from the hit side and face flag, and the texture
// column from a bit-serial multiply of distance by ray direction, 24 steps; a
// setup word returns nothing. A pixel word (tuser 1) gives a row: ceiling and
// floor rows return their color, rows at or past SCREEN_HEIGHT return nothing,
// and wall rows go through the 8-step serial divider by line height. One word is
// worked on at a time; the next is taken while the result waits in the output
// register. Depends on rctm_pkg, rctm_mul_serial, rctm_div_serial and the
// macros header.
`default_nettype none
`include "raycast_column_texel_mapper_unit_macros.svh"

module raycast_column_texel_mapper_unit
    import rctm_pkg::*;
#(
    parameter int SCREEN_HEIGHT = 480
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // position[9:0] hit_side[10] face_flag[11] player_x[33:12] player_y[55:34]
    // wall_distance[79:56] dir_x[97:80] dir_y[115:98] wall_height[131:116]
    // span_start[140:132] span_end[149:141], zero pad above
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // kind[0]
    input  wire logic [0:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // column[9:0] row[18:10] pixel_color[50:19] texture_face[52:51]
    // texel_index[68:53], zero pad above
    output logic [M_DATA_W-1:0]       m_tdata,
    // pixel_class[1:0]
    output logic [1:0]                m_tuser
);

    localparam logic [10:0] SCREEN_ROWS = 11'(SCREEN_HEIGHT);
    localparam logic [17:0] HALF_ROWS   = 18'(SCREEN_HEIGHT / 2);

    // input fields
    logic [9:0]        in_pos;
    logic              in_side;
    logic              in_flag;
    logic [21:0]       in_px;
    logic [21:0]       in_py;
    logic [DIST_W-1:0] in_dist;
    logic [DIR_W-1:0]  in_dx;
    logic [DIR_W-1:0]  in_dy;
    logic [LH_W-1:0]   in_lh;
    logic [8:0]        in_start;
    logic [8:0]        in_end;

    assign in_pos   = s_tdata[9:0];
    assign in_side  = s_tdata[10];
    assign in_flag  = s_tdata[11];
    assign in_px    = s_tdata[33:12];
    assign in_py    = s_tdata[55:34];
    assign in_dist  = s_tdata[79:56];
    assign in_dx    = s_tdata[97:80];
    assign in_dy    = s_tdata[115:98];
    assign in_lh    = s_tdata[131:116];
    assign in_start = s_tdata[140:132];
    assign in_end   = s_tdata[149:141];

    // configuration
    logic [TEX_W-1:0] tex_width_reg;
    logic [TEX_W-1:0] tex_height_reg;
    logic [31:0]      ceil_color_reg;
    logic [31:0]      floor_color_reg;

    // column state
    logic [9:0]      cur_column_reg;
    logic [1:0]      cur_face_reg;
    logic [7:0]      tex_column_reg;
    logic [LH_W-1:0] lh_held_reg;
    logic [8:0]      first_row_reg;
    logic [8:0]      end_row_reg;

    // work registers
    logic [15:0]        off_reg;
    logic [NUMER_W-1:0] numer_reg;
    logic [TEX_W-1:0]   scale_reg;
    logic [QUOT_W-1:0]  ty_reg;

    logic [8:0]  res_row_reg;
    logic [1:0]  res_class_reg;
    logic [31:0] res_color_reg;
    logic [1:0]  res_face_reg;
    logic [15:0] res_index_reg;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    rctm_state_t state_reg;
    rctm_state_t state_next;

    logic in_accept;
    logic out_load;
    logic mul_start;
    logic div_start;

    logic [TEX_W-1:0] tw;
    logic [TEX_W-1:0] th;
    logic [TEX_W-1:0] th_m1;

    logic [1:0]        setup_face;
    logic [21:0]       setup_base;
    logic [DIR_W-1:0]  setup_dir;
    logic [FRAC_W-1:0] mul_product;
    logic              mul_done;

    logic              row_off_screen;
    logic              row_ceiling;
    logic              row_wall;
    logic [17:0]       off_full;
    logic [15:0]       off_sat;

    logic [40:0]       scale_prod;
    logic [TEX_W-1:0]  mirrored;
    logic              mirror_face;
    logic [16:0]       idx_prod;
    logic [16:0]       idx_sum;
    logic [QUOT_W-1:0] ty_sat;

    rctm_div_stat_t    div_stat;
    logic [QUOT_W-1:0] div_quot;

    assign tw    = rctm_tex_size(tex_width_reg);
    assign th    = rctm_tex_size(tex_height_reg);
    assign th_m1 = th - 1'b1;

    assign in_accept = s_tvalid && s_tready;

    // setup decode
    always_comb begin
        if (!in_side) begin
            setup_face = in_flag ? FACE_XS_POS : FACE_XS_NEG;
            setup_base = in_py;
            setup_dir  = in_dy;
        end else begin
            setup_face = in_flag ? FACE_YS_NEG : FACE_YS_POS;
            setup_base = in_px;
            setup_dir  = in_dx;
        end
    end

    // pixel decode
    always_comb begin
        row_off_screen = {1'b0, in_pos} >= SCREEN_ROWS;
        row_ceiling    = in_pos < {1'b0, first_row_reg};
        row_wall       = !row_ceiling && (in_pos < {1'b0, end_row_reg});
        off_full       = 18'(in_pos) - HALF_ROWS + 18'(lh_held_reg[LH_W-1:1]);
        off_sat        = off_full[17] ? 16'd0 : off_full[15:0];
    end

    // arithmetic between stages
    always_comb begin
        scale_prod  = 41'(mul_product) * 41'(tw);
        mirror_face = (cur_face_reg == FACE_YS_POS) || (cur_face_reg == FACE_XS_NEG);
        mirrored    = tw - scale_reg - 1'b1;
        ty_sat      = (div_stat.over || (div_quot > th_m1[QUOT_W-1:0]))
                      ? th_m1[QUOT_W-1:0] : div_quot;
        idx_prod    = 17'(tw) * 17'(ty_reg);
        idx_sum     = idx_prod + 17'(tex_column_reg);
    end

    rctm_mul_serial u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mul_start),
        .dist_in  (in_dist),
        .dir_in   (FRAC_W'($signed(setup_dir))),
        .acc_init ({setup_base[15:0], 16'd0}),
        .done     (mul_done),
        .product  (mul_product)
    );

    rctm_div_serial u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start),
        .numer_in   (numer_reg),
        .divisor_in (lh_held_reg),
        .stat       (div_stat),
        .quotient   (div_quot)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_tuser[0] == KIND_SETUP) begin
                        state_next = ST_SETUP_MUL;
                    end else if (row_off_screen) begin
                        state_next = ST_IDLE;
                    end else if (row_wall) begin
                        state_next = ST_PIX_NUMER;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SETUP_MUL: begin
                if (mul_done) begin
                    state_next = ST_SETUP_SCALE;
                end
            end
            ST_SETUP_SCALE:  state_next = ST_SETUP_MIRROR;
            ST_SETUP_MIRROR: state_next = ST_IDLE;
            ST_PIX_NUMER:    state_next = ST_PIX_START;
            ST_PIX_START:    state_next = ST_PIX_DIVIDE;
            ST_PIX_DIVIDE: begin
                if (div_stat.done) begin
                    state_next = ST_PIX_INDEX;
                end
            end
            ST_PIX_INDEX:    state_next = ST_RESULT;
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:         state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                mul_start = s_tvalid && (s_tuser[0] == KIND_SETUP);
            end
            ST_PIX_START: div_start = 1'b1;
            ST_RESULT:    out_load  = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration and column state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_width_reg   <= TEX_SIZE_RESET;
            tex_height_reg  <= TEX_SIZE_RESET;
            ceil_color_reg  <= '0;
            floor_color_reg <= '0;
            cur_column_reg  <= '0;
            cur_face_reg    <= '0;
            tex_column_reg  <= '0;
            lh_held_reg     <= LH_W'(1);
            first_row_reg   <= '0;
            end_row_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_TEX_WIDTH:   tex_width_reg   <= cfg_wdata[TEX_W-1:0];
                    CFG_TEX_HEIGHT:  tex_height_reg  <= cfg_wdata[TEX_W-1:0];
                    CFG_CEIL_COLOR:  ceil_color_reg  <= cfg_wdata;
                    CFG_FLOOR_COLOR: floor_color_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (in_accept && (s_tuser[0] == KIND_SETUP)) begin
                cur_column_reg <= in_pos;
                cur_face_reg   <= setup_face;
                lh_held_reg    <= (in_lh == '0) ? LH_W'(1) : in_lh;
                first_row_reg  <= in_start;
                end_row_reg    <= in_end;
            end
            if (state_reg == ST_SETUP_MIRROR) begin
                tex_column_reg <= mirror_face ? mirrored[7:0] : scale_reg[7:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_accept && (s_tuser[0] == KIND_PIXEL)) begin
            res_row_reg   <= in_pos[8:0];
            off_reg       <= off_sat;
            res_index_reg <= '0;
            priority if (row_ceiling) begin
                res_class_reg <= CLASS_CEILING;
                res_color_reg <= ceil_color_reg;
                res_face_reg  <= '0;
            end else if (row_wall) begin
                res_class_reg <= CLASS_WALL;
                res_color_reg <= '0;
                res_face_reg  <= cur_face_reg;
            end else begin
                res_class_reg <= CLASS_FLOOR;
                res_color_reg <= floor_color_reg;
                res_face_reg  <= '0;
            end
        end
        if (state_reg == ST_SETUP_SCALE) begin
            scale_reg <= scale_prod[40:32];
        end
        if (state_reg == ST_PIX_NUMER) begin
            numer_reg <= NUMER_W'(off_reg) * NUMER_W'(th);
        end
        if ((state_reg == ST_PIX_DIVIDE) && div_stat.done) begin
            ty_reg <= ty_sat;
        end
        if (state_reg == ST_PIX_INDEX) begin
            res_index_reg <= idx_sum[15:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {3'd0, res_index_reg, res_face_reg, res_color_reg,
                            res_row_reg, cur_column_reg};
            m_tuser_reg <= res_class_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `RCTM_ASSERT_NOW(a_mul_done_in_setup, aclk, aresetn, mul_done, state_reg == ST_SETUP_MUL)
    `RCTM_ASSERT_NOW(a_div_done_in_pixel, aclk, aresetn, div_stat.done, state_reg == ST_PIX_DIVIDE)
    `RCTM_ASSERT_NEXT(a_load_shows_word, aclk, aresetn, out_load, m_tvalid && (state_reg == ST_IDLE))

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for raycast_column_texel_mapper_unit.
// Streams column setup and pixel row words and checks each result against a
// built-in predictor. Depends on rctm_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench
    import rctm_pkg::*;
();

    localparam int SCREEN_H      = 480;
    localparam int SCREEN_W      = 640;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int IDLE_PCT      = 28;
    localparam int PHASE_WORDS   = 330;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = CFG_IDX_W'(CFG_FLOOR_COLOR + 1);

    typedef struct {
        logic               kind;
        logic [9:0]         position;
        logic               hit_side;
        logic               face_flag;
        logic [21:0]        player_x;
        logic [21:0]        player_y;
        logic [23:0]        distance;
        logic signed [17:0] dir_x;
        logic signed [17:0] dir_y;
        logic [15:0]        wall_height;
        logic [8:0]         span_start;
        logic [8:0]         span_stop;
    } ray_word_t;

    typedef struct {
        logic [9:0]  column;
        logic [8:0]  row;
        logic [1:0]  pixel_class;
        logic [31:0] pixel_color;
        logic [1:0]  face;
        logic [15:0] texel_index;
    } texel_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [1:0]           m_tuser;

    // register copies and column state of the predictor
    logic [8:0]  tex_w_reg       = TEX_SIZE_RESET;
    logic [8:0]  tex_h_reg       = TEX_SIZE_RESET;
    logic [31:0] ceil_color_reg  = '0;
    logic [31:0] floor_color_reg = '0;
    logic [9:0]  col_q           = '0;
    logic [1:0]  face_q          = '0;
    logic [7:0]  tex_col_q       = '0;
    logic [15:0] lh_q            = 16'd1;
    logic [8:0]  span_first_q    = '0;
    logic [8:0]  span_stop_q     = '0;

    ray_word_t     word_q[$];
    texel_result_t texel_expect_q[$];
    ray_word_t     word_on_bus;
    logic          no_idle     = 1'b0;
    int            err_count   = 0;
    int            cycle_count = 0;

    raycast_column_texel_mapper_unit #(
        .SCREEN_HEIGHT(SCREEN_H)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic longint unsigned tex_dim(input logic [8:0] v);
        if (v == '0) begin
            return 1;
        end
        if (v > TEX_SIZE_MAX) begin
            return TEX_SIZE_MAX;
        end
        return v;
    endfunction

    function automatic void predict_texel(input ray_word_t wd);
        longint unsigned w, h, base, frac, tx, ty;
        longint          prod, off;
        texel_result_t   r;
        w = tex_dim(tex_w_reg);
        h = tex_dim(tex_h_reg);
        if (wd.kind == KIND_SETUP) begin
            if (wd.hit_side == 1'b0) begin
                face_q = wd.face_flag ? FACE_XS_POS : FACE_XS_NEG;
                base   = wd.player_y;
                prod   = longint'(wd.distance) * longint'(wd.dir_y);
            end else begin
                face_q = wd.face_flag ? FACE_YS_NEG : FACE_YS_POS;
                base   = wd.player_x;
                prod   = longint'(wd.distance) * longint'(wd.dir_x);
            end
            // floor-based fraction of the hit coordinate, also for negative sums
            frac = ((base << 16) + $unsigned(prod)) & 64'h0000_0000_FFFF_FFFF;
            tx   = (frac * w) >> 32;
            if (face_q == FACE_YS_POS || face_q == FACE_XS_NEG) begin
                tx = w - tx - 1;
            end
            col_q        = wd.position;
            tex_col_q    = 8'(tx);
            lh_q         = (wd.wall_height == '0) ? 16'd1 : wd.wall_height;
            span_first_q = wd.span_start;
            span_stop_q  = wd.span_stop;
            return;
        end
        if (wd.position >= SCREEN_H) begin
            return;
        end
        r.column      = col_q;
        r.row         = wd.position[8:0];
        r.pixel_color = '0;
        r.face        = '0;
        r.texel_index = '0;
        if (wd.position < span_first_q) begin
            r.pixel_class = CLASS_CEILING;
            r.pixel_color = ceil_color_reg;
        end else if (wd.position < span_stop_q) begin
            off = longint'(wd.position) - SCREEN_H / 2 + longint'(lh_q / 2);
            if (off < 0) begin
                off = 0;
            end
            ty = ($unsigned(off) * h) / lh_q;
            if (ty > h - 1) begin
                ty = h - 1;
            end
            r.pixel_class = CLASS_WALL;
            r.face        = face_q;
            r.texel_index = 16'(w * ty + tex_col_q);
        end else begin
            r.pixel_class = CLASS_FLOOR;
            r.pixel_color = floor_color_reg;
        end
        texel_expect_q.push_back(r);
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_word(input ray_word_t wd);
        return {2'b00, wd.span_stop, wd.span_start, wd.wall_height, wd.dir_y, wd.dir_x,
                wd.distance, wd.player_y, wd.player_x, wd.face_flag, wd.hit_side,
                wd.position};
    endfunction

    function automatic ray_word_t random_word();
        ray_word_t wd;
        wd.kind        = 1'($urandom_range(0, 1));
        wd.position    = 10'($urandom);
        wd.hit_side    = 1'($urandom_range(0, 1));
        wd.face_flag   = 1'($urandom_range(0, 1));
        wd.player_x    = 22'($urandom);
        wd.player_y    = 22'($urandom);
        wd.distance    = 24'($urandom);
        wd.dir_x       = 18'($urandom);
        wd.dir_y       = 18'($urandom);
        wd.wall_height = 16'($urandom);
        wd.span_start  = 9'($urandom);
        wd.span_stop   = 9'($urandom);
        return wd;
    endfunction

    function automatic ray_word_t make_setup(input int unsigned col, input logic side,
                                             input logic flag, input int unsigned lh,
                                             input int unsigned first,
                                             input int unsigned stop);
        ray_word_t wd;
        wd             = random_word();
        wd.kind        = KIND_SETUP;
        wd.position    = 10'(col);
        wd.hit_side    = side;
        wd.face_flag   = flag;
        wd.wall_height = 16'(lh);
        wd.span_start  = 9'(first);
        wd.span_stop   = 9'(stop);
        return wd;
    endfunction

    function automatic ray_word_t make_pixel(input int unsigned row);
        ray_word_t wd;
        wd          = random_word();
        wd.kind     = KIND_PIXEL;
        wd.position = 10'(row);
        return wd;
    endfunction

    // one column: a setup word followed by a run of rows, mostly in or around its wall span
    function automatic int column_run();
        ray_word_t   wd;
        int unsigned lh, first, stop, n, row, pick, top;
        wd = make_setup(0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 0, 0, 0);
        wd.position = ($urandom_range(0, 15) != 0) ? 10'($urandom_range(0, SCREEN_W - 1))
                                                   : 10'($urandom);
        lh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 1200);
        if ($urandom_range(0, 9) < 7) begin
            first = (lh / 2 >= SCREEN_H / 2) ? 0 : SCREEN_H / 2 - lh / 2;
            stop  = (SCREEN_H / 2 + lh / 2 > SCREEN_H) ? SCREEN_H : SCREEN_H / 2 + lh / 2;
        end else begin
            first = $urandom_range(0, 511);
            stop  = $urandom_range(0, 511);
        end
        if ($urandom_range(0, 3) == 0) begin
            wd.distance = 24'($urandom_range(0, 24'h0F_FFFF));
        end
        wd.wall_height = 16'(lh);
        wd.span_start  = 9'(first);
        wd.span_stop   = 9'(stop);
        word_q.push_back(wd);
        n   = $urandom_range(3, 24);
        top = (stop > SCREEN_H) ? SCREEN_H : stop;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45 && first < top) begin
                row = $urandom_range(first, top - 1);
            end else if (pick < 70) begin
                case ($urandom_range(0, 3))
                    0: row = first;
                    1: row = (first == 0) ? 0 : first - 1;
                    2: row = stop;
                    default: row = (stop == 0) ? 0 : stop - 1;
                endcase
            end else if (pick < 95) begin
                row = $urandom_range(0, SCREEN_H - 1);
            end else begin
                row = $urandom_range(SCREEN_H, 1023);
            end
            word_q.push_back(make_pixel(row));
        end
        return n + 1;
    endfunction

    task automatic random_phase(input int target);
        int pushed;
        pushed = 0;
        while (pushed < target) begin
            if ($urandom_range(0, 19) == 0) begin
                word_q.push_back(random_word());
                pushed++;
            end else begin
                pushed += column_run();
            end
        end
    endtask

    task automatic directed_run();
        ray_word_t wd;
        // before any setup the stored span is empty: floor
        word_q.push_back(make_pixel(0));
        wd = make_setup(0, 1'b0, 1'b1, 100, 190, 290);
        wd.player_x = '0;
        wd.player_y = '1;
        wd.distance = '1;
        wd.dir_y    = 18'sh1FFFF;
        word_q.push_back(wd);
        word_q.push_back(make_pixel(189));
        word_q.push_back(make_pixel(190));
        word_q.push_back(make_pixel(289));
        word_q.push_back(make_pixel(290));
        // zero line height, full-screen span, offscreen rows
        wd = make_setup(SCREEN_W - 1, 1'b0, 1'b0, 0, 0, SCREEN_H);
        wd.distance = '0;
        wd.dir_x    = 18'sh20000;
        wd.dir_y    = 18'sh20000;
        word_q.push_back(wd);
        word_q.push_back(make_pixel(0));
        word_q.push_back(make_pixel(SCREEN_H - 1));
        word_q.push_back(make_pixel(SCREEN_H));
        word_q.push_back(make_pixel(1023));
        wd = make_setup(1023, 1'b1, 1'b1, 16'hFFFF, 0, SCREEN_H);
        wd.player_x = '1;
        wd.distance = '1;
        wd.dir_x    = 18'sh20000;
        word_q.push_back(wd);
        word_q.push_back(make_pixel(SCREEN_H - 1));
        word_q.push_back(make_pixel(0));
        // inverted span: no wall rows at all
        wd = make_setup(5, 1'b1, 1'b0, 1, 300, 200);
        wd.dir_x = 18'sh1FFFF;
        word_q.push_back(wd);
        word_q.push_back(make_pixel(250));
        word_q.push_back(make_pixel(350));
        // negative texture offset and texture row past the end
        wd = make_setup(320, 1'b1, 1'b0, 100, 0, SCREEN_H);
        word_q.push_back(wd);
        word_q.push_back(make_pixel(10));
        word_q.push_back(make_pixel(400));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_TEX_WIDTH:   tex_w_reg = val[8:0];
            CFG_TEX_HEIGHT:  tex_h_reg = val[8:0];
            CFG_CEIL_COLOR:  ceil_color_reg = val;
            CFG_FLOOR_COLOR: floor_color_reg = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] w, input logic [31:0] h,
                             input logic [31:0] ceil_c, input logic [31:0] floor_c);
        write_reg(CFG_TEX_WIDTH, w);
        write_reg(CFG_TEX_HEIGHT, h);
        write_reg(CFG_CEIL_COLOR, ceil_c);
        write_reg(CFG_FLOOR_COLOR, floor_c);
        write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_UNUSED_LO, (1 << CFG_IDX_W) - 1)),
                  $urandom);
    endtask

    // everything sent and answered, then room for a setup word still in flight
    task automatic settle();
        while (word_q.size() != 0 || s_tvalid || texel_expect_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic report(input string field, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h", field, got, want);
        err_count++;
    endtask

    task automatic compare_field(input string field, input longint got, input longint want);
        if (got != want) begin
            report(field, got, want);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_texel(word_on_bus);
            end
            if (!s_tvalid || s_tready) begin
                if (word_q.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    word_on_bus = word_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= pack_word(word_on_bus);
                    s_tuser  <= word_on_bus.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        texel_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (texel_expect_q.size() == 0) begin
                    report("unexpected word", longint'(m_tdata[63:0]), 0);
                end else begin
                    want = texel_expect_q.pop_front();
                    compare_field("column", m_tdata[9:0], want.column);
                    compare_field("row", m_tdata[18:10], want.row);
                    compare_field("pixel_class", m_tuser, want.pixel_class);
                    compare_field("pixel_color", m_tdata[50:19], want.pixel_color);
                    compare_field("texture_face", m_tdata[52:51], want.face);
                    compare_field("texel_index", m_tdata[68:53], want.texel_index);
                end
            end
            m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        directed_run();
        settle();

        write_all(32'(TEX_SIZE_MAX), 32'(TEX_SIZE_MAX), 32'hFFFF_FFFF, 32'h0);
        random_phase(PHASE_WORDS);
        settle();

        // back-to-back traffic on both sides
        write_all(32'(TEX_SIZE_MIN), 32'(TEX_SIZE_MIN), 32'h0, 32'hFFFF_FFFF);
        no_idle = 1'b1;
        random_phase(PHASE_WORDS);
        settle();
        no_idle = 1'b0;

        // out-of-range texture sizes: zero acts as one, above the max clamps
        write_all(32'h0, 32'h1FF, $urandom, $urandom);
        random_phase(PHASE_WORDS);
        settle();

        write_all(32'h1FF, 32'h0, $urandom, $urandom);
        random_phase(PHASE_WORDS);
        settle();

        write_all($urandom_range(1, TEX_SIZE_MAX), $urandom_range(1, TEX_SIZE_MAX),
                  $urandom, $urandom);
        random_phase(PHASE_WORDS);
        settle();

        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/rctm_pkg.sv
rtl/core/rctm_mul_serial.sv
rtl/core/rctm_div_serial.sv
rtl/core/raycast_column_texel_mapper_unit.sv
sim/testbench.sv
